// File: rtl/wsfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame receiver package
// Parse phases and frame format constants shared by the receiver and its
// channel interfaces.
// ----------------------------------------------------------------------------
package wsfr_pkg;

   localparam int unsigned ByteW = 8;
   localparam int unsigned LenW  = 16;
   localparam int unsigned KeyN  = 4;
   localparam int unsigned KeyIdxW = $clog2(KeyN);

   localparam logic [ByteW-1:0] MASK_BIT  = 8'h80;
   localparam logic [6:0]       LEN_EXT16 = 7'd126;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_LEN     = 3'd1,
      PH_EXT_HI  = 3'd2,
      PH_EXT_LO  = 3'd3,
      PH_MASK    = 3'd4,
      PH_PAYLOAD = 3'd5
   } phase_type;

endpackage

// File: rtl/wsfr_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame receiver channels
// Valid/ready channel interfaces for received bytes and payload results.
// ----------------------------------------------------------------------------
interface wsfr_req_if import wsfr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsfr_rsp_if import wsfr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] payload_byte;
   logic             payload_valid;
   logic             end_of_message;
   logic [ByteW-1:0] frame_header;

   modport source (output valid, output payload_byte, output payload_valid,
                   output end_of_message, output frame_header, input ready);
   modport sink   (input valid, input payload_byte, input payload_valid,
                   input end_of_message, input frame_header, output ready);
endinterface

// File: rtl/websocket_frame_receiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame receiver
// Parses header, length, extended length and mask key bytes, and emits each
// payload byte unmasked, with the last byte of the frame marked; an empty frame gives one result with no payload byte.
// ----------------------------------------------------------------------------
//  channel   direction  payload                                     handshake
//  req_ch    in         rx_byte                                     valid/ready
//  rsp_ch    out        payload_byte, payload_valid,                valid/ready
//                       end_of_message, frame_header
//
//  One byte is taken per cycle unless a stalled result fills both stages;
//  a result passes the input register, then the result register.
//  Parse state updates in the cycle a registered byte moves on, so the
//  phase register and the byte counter set the one-byte-per-cycle rate.
//  A stalled result holds the byte stage; req_ch.ready drops only when both
//  stages are full and the result is not taken.
//  Synchronous active-high reset returns to the header phase and empties
//  both stages.
// ----------------------------------------------------------------------------
module websocket_frame_receiver_top import wsfr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   wsfr_req_if.sink   req_ch,
   wsfr_rsp_if.source rsp_ch
);

   // byte stage
   logic             byte_valid_ff;
   logic [ByteW-1:0] byte_data_ff;

   // parse state
   phase_type        phase_ff, phase_in;
   logic [ByteW-1:0] header_ff, header_in;
   logic             masked_ff, masked_in;
   logic [LenW-1:0]  length_ff, length_in;
   logic [LenW-1:0]  count_ff, count_in;
   logic [ByteW-1:0] key_ff [KeyN];
   logic             key_we;

   // result stage
   logic             rsp_valid_ff;
   logic [ByteW-1:0] rsp_byte_ff, rsp_byte_in;
   logic             rsp_pvalid_ff, rsp_pvalid_in;
   logic             rsp_eom_ff, rsp_eom_in;
   logic [ByteW-1:0] rsp_header_ff;
   logic             emit;

   logic             out_free;
   logic             advance;
   logic [LenW-1:0]  count_inc;
   logic [ByteW-1:0] key_sel;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = byte_valid_ff && out_free;
   assign req_ch.ready = !byte_valid_ff || out_free;
   assign count_inc    = count_ff + LenW'(1);
   assign key_sel      = masked_ff ? key_ff[count_ff[KeyIdxW-1:0]] : '0;

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.payload_byte   = rsp_byte_ff;
   assign rsp_ch.payload_valid  = rsp_pvalid_ff;
   assign rsp_ch.end_of_message = rsp_eom_ff;
   assign rsp_ch.frame_header   = rsp_header_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         byte_valid_ff <= req_ch.valid;
      end
      if (req_ch.ready && req_ch.valid) begin
         byte_data_ff <= req_ch.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         header_ff <= '0;
         masked_ff <= 1'b0;
         length_ff <= '0;
         count_ff  <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         header_ff <= header_in;
         masked_ff <= masked_in;
         length_ff <= length_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && key_we) begin
         key_ff[count_ff[KeyIdxW-1:0]] <= byte_data_ff;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      header_in     = header_ff;
      masked_in     = masked_ff;
      length_in     = length_ff;
      count_in      = count_ff;
      key_we        = 1'b0;
      emit          = 1'b0;
      rsp_byte_in   = '0;
      rsp_pvalid_in = 1'b0;
      rsp_eom_in    = 1'b0;
      unique case (phase_ff)
         PH_LEN: begin
            masked_in = byte_data_ff[7];
            if (byte_data_ff[6:0] == LEN_EXT16) begin
               phase_in = PH_EXT_HI;
            end else begin
               length_in = LenW'(byte_data_ff[6:0]);
               count_in  = '0;
               if ((byte_data_ff & MASK_BIT) != '0) begin
                  phase_in = PH_MASK;
               end else if (byte_data_ff[6:0] == 7'd0) begin
                  phase_in   = PH_HEADER;
                  emit       = 1'b1;
                  rsp_eom_in = 1'b1;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_EXT_HI: begin
            length_in = {byte_data_ff, 8'h00};
            phase_in  = PH_EXT_LO;
         end
         PH_EXT_LO: begin
            length_in = {length_ff[LenW-1:ByteW], byte_data_ff};
            count_in  = '0;
            if (masked_ff) begin
               phase_in = PH_MASK;
            end else if ({length_ff[LenW-1:ByteW], byte_data_ff} == '0) begin
               phase_in   = PH_HEADER;
               emit       = 1'b1;
               rsp_eom_in = 1'b1;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_MASK: begin
            key_we   = 1'b1;
            count_in = count_inc;
            // fourth key byte completes the header
            if (count_inc >= LenW'(KeyN)) begin
               count_in = '0;
               if (length_ff == '0) begin
                  phase_in   = PH_HEADER;
                  emit       = 1'b1;
                  rsp_eom_in = 1'b1;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            count_in      = count_inc;
            emit          = 1'b1;
            rsp_byte_in   = byte_data_ff ^ key_sel;
            rsp_pvalid_in = 1'b1;
            rsp_eom_in    = (count_inc == length_ff);
            if (count_inc == length_ff) begin
               phase_in = PH_HEADER;
            end
         end
         default: begin
            header_in = byte_data_ff;
            phase_in  = PH_LEN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance && emit;
      end
      if (out_free && advance && emit) begin
         rsp_byte_ff   <= rsp_byte_in;
         rsp_pvalid_ff <= rsp_pvalid_in;
         rsp_eom_ff    <= rsp_eom_in;
         rsp_header_ff <= header_ff;
      end
   end

   // an empty-frame result always closes its frame
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_pvalid_ff |-> rsp_eom_ff)
      else $error("empty result without end_of_message");

   a_mask_phase_masked: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_MASK |-> masked_ff)
      else $error("mask key phase in an unmasked frame");

   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> count_ff < length_ff)
      else $error("payload count ran past frame length");

   a_payload_emits: assert property (@(posedge clock) disable iff (reset)
      advance && phase_ff == PH_PAYLOAD |=> rsp_valid_ff && rsp_pvalid_ff)
      else $error("payload byte produced no result");

   a_key_phase_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_MASK |-> count_ff < LenW'(KeyN))
      else $error("mask key count out of range");

endmodule

// File: tb/tb_websocket_frame_receiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame receiver testbench
// Streams frame bytes into the receiver through bursts and gaps, predicts the
// unmasked payload results in step with each accepted byte, and checks every
// result transaction against the oldest prediction while the result side
// stalls on a pattern and, once, holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_websocket_frame_receiver_top;
   import wsfr_pkg::*;

   localparam int unsigned ItemTarget    = 1350;
   localparam int unsigned HoldCycles    = 300;
   localparam int unsigned WatchdogLimit = 2000;
   localparam int unsigned DrainCycles   = 8;

   typedef struct packed {
      logic [ByteW-1:0] data;
      logic             data_valid;
      logic             eom;
      logic [ByteW-1:0] header;
   } payload_rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wsfr_req_if req_ch ();
   wsfr_rsp_if rsp_ch ();

   websocket_frame_receiver_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predicted parser state
   phase_type        prs_phase;
   logic [ByteW-1:0] cur_header;
   logic             cur_masked;
   logic [LenW-1:0]  frame_len;
   logic [LenW-1:0]  frame_cnt;
   logic [ByteW-1:0] mask_key_r [KeyN];

   payload_rec_type  unmasked_q [$];
   int unsigned      mismatch_count = 0;
   int unsigned      bytes_sent = 0;

   // sender pacing
   int unsigned      burst_left = 0;
   bit               sender_gaps = 1'b0;

   // receiver pacing
   bit               rsp_stall = 1'b0;
   int unsigned      hold_req = 0;
   int unsigned      hold_ack = 0;
   int unsigned      hold_left = 0;
   logic [15:0]      stall_pat = 16'h0001;
   int unsigned      pat_age = 0;
   int unsigned      idle_cycles = 0;

   task automatic open_payload();
      frame_cnt = '0;
      if (frame_len == '0) begin
         prs_phase = PH_HEADER;
         unmasked_q.push_back('{data: '0, data_valid: 1'b0, eom: 1'b1,
                                header: cur_header});
      end else begin
         prs_phase = PH_PAYLOAD;
      end
   endtask

   task automatic deframe_byte(input logic [ByteW-1:0] b);
      logic [ByteW-1:0] key;
      logic             last;
      case (prs_phase)
         PH_LEN: begin
            cur_masked = (b & MASK_BIT) != '0;
            if (b[6:0] == LEN_EXT16) begin
               prs_phase = PH_EXT_HI;
            end else begin
               frame_len = LenW'(b[6:0]);
               if (cur_masked) begin
                  frame_cnt = '0;
                  prs_phase = PH_MASK;
               end else begin
                  open_payload();
               end
            end
         end
         PH_EXT_HI: begin
            frame_len = {b, 8'h00};
            prs_phase = PH_EXT_LO;
         end
         PH_EXT_LO: begin
            frame_len = frame_len | LenW'(b);
            if (cur_masked) begin
               frame_cnt = '0;
               prs_phase = PH_MASK;
            end else begin
               open_payload();
            end
         end
         PH_MASK: begin
            mask_key_r[frame_cnt[KeyIdxW-1:0]] = b;
            frame_cnt = frame_cnt + LenW'(1);
            if (frame_cnt >= LenW'(KeyN)) open_payload();
         end
         PH_PAYLOAD: begin
            key = cur_masked ? mask_key_r[frame_cnt[KeyIdxW-1:0]] : '0;
            frame_cnt = frame_cnt + LenW'(1);
            last = (frame_cnt == frame_len);
            if (last) prs_phase = PH_HEADER;
            unmasked_q.push_back('{data: b ^ key, data_valid: 1'b1, eom: last,
                                   header: cur_header});
         end
         default: begin
            cur_header = b;
            prs_phase = PH_LEN;
         end
      endcase
   endtask

   // Offer one byte, hold until accepted, then maybe open a gap.
   task automatic send_byte(input logic [ByteW-1:0] b);
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      deframe_byte(b);
      bytes_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else if (sender_gaps) begin
         req_ch.valid   <= 1'b0;
         req_ch.rx_byte <= ByteW'($urandom);
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(8, 20)) @(posedge clock);
         else repeat ($urandom_range(1, 4)) @(posedge clock);
         burst_left = $urandom_range(0, 15);
      end
   endtask

   task automatic send_frame(input logic [ByteW-1:0] hdr, input bit masked,
                             input int unsigned len, input bit use_ext);
      logic [LenW-1:0] flen;
      flen = LenW'(len);
      send_byte(hdr);
      if (use_ext || flen == LenW'(LEN_EXT16) || flen > 16'd127) begin
         send_byte({masked, LEN_EXT16});
         send_byte(flen[15:8]);
         send_byte(flen[7:0]);
      end else begin
         send_byte({masked, flen[6:0]});
      end
      if (masked) repeat (KeyN) send_byte(ByteW'($urandom));
      repeat (len) send_byte(ByteW'($urandom));
   endtask

   // Empty frames (short unmasked, short masked, extended unmasked), a single byte frame and byte extremes.
   task automatic test_directed();
      logic [ByteW-1:0] seq [$];
      seq = '{8'h81, 8'h00,
              8'h00, 8'h01, 8'hFF,
              8'hFF, 8'h80, 8'h11, 8'h22, 8'h33, 8'h44,
              8'h82, 8'h82, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h00, 8'hFF,
              8'h88, 8'h7E, 8'h00, 8'h00};
      sender_gaps = 1'b0;
      rsp_stall <= 1'b0;
      foreach (seq[i]) send_byte(seq[i]);
   endtask

   // Length code 127 is a plain length, not a 64-bit extension.
   task automatic test_literal_127();
      sender_gaps = 1'b1;
      rsp_stall <= 1'b1;
      send_frame(8'h82, 1'b1, 127, 1'b0);
   endtask

   task automatic test_extended_length();
      sender_gaps = 1'b1;
      rsp_stall <= 1'b1;
      send_frame(ByteW'($urandom), 1'b1, 0, 1'b1);
      send_frame(ByteW'($urandom), 1'b0, 5, 1'b1);
      send_frame(ByteW'($urandom), 1'b1, 126, 1'b1);
      send_frame(ByteW'($urandom), 1'b0, 300, 1'b1);
   endtask

   // Hold the result side off while bytes keep coming, so the input stalls.
   task automatic test_backpressure();
      sender_gaps = 1'b0;
      rsp_stall <= 1'b0;
      hold_req <= hold_req + 1;
      repeat (4) send_frame(ByteW'($urandom), 1'b1, 24, 1'b0);
   endtask

   task automatic test_random_frames();
      int unsigned pick;
      int unsigned len;
      int unsigned n;
      bit          use_ext;
      while (bytes_sent < ItemTarget) begin
         if ($urandom_range(0, 7) == 0) begin
            sender_gaps = $urandom_range(0, 2) != 0;
            rsp_stall <= $urandom_range(0, 2) != 0;
         end
         if ($urandom_range(0, 99) < 12) begin
            // raw bytes; keep extended lengths short, then finish the frame
            n = $urandom_range(1, 12);
            while (n > 0 || prs_phase != PH_HEADER) begin
               send_byte(prs_phase == PH_EXT_HI ? ByteW'($urandom_range(0, 1))
                                                : ByteW'($urandom));
               if (n > 0) n--;
            end
         end else begin
            pick = $urandom_range(0, 99);
            use_ext = 1'b0;
            if (pick < 50) begin
               len = $urandom_range(0, 8);
            end else if (pick < 75) begin
               len = $urandom_range(9, 40);
            end else if (pick < 85) begin
               len = $urandom_range(120, 127);
            end else if (pick < 95) begin
               len = $urandom_range(0, 60);
               use_ext = 1'b1;
            end else begin
               len = $urandom_range(126, 300);
               use_ext = 1'b1;
            end
            send_frame(ByteW'($urandom), bit'($urandom_range(0, 1)), len, use_ext);
         end
      end
   endtask

   // Result side: check, then choose ready for the next cycle.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (unmasked_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: byte %h valid %b eom %b header %h",
                           rsp_ch.payload_byte, rsp_ch.payload_valid,
                           rsp_ch.end_of_message, rsp_ch.frame_header);
            end else if (rsp_ch.payload_byte   !== unmasked_q[0].data ||
                         rsp_ch.payload_valid  !== unmasked_q[0].data_valid ||
                         rsp_ch.end_of_message !== unmasked_q[0].eom ||
                         rsp_ch.frame_header   !== unmasked_q[0].header) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("result differs: expected byte %h valid %b eom %b header %h",
                           unmasked_q[0].data, unmasked_q[0].data_valid,
                           unmasked_q[0].eom, unmasked_q[0].header);
                  $display("                got byte %h valid %b eom %b header %h",
                           rsp_ch.payload_byte, rsp_ch.payload_valid,
                           rsp_ch.end_of_message, rsp_ch.frame_header);
               end
               void'(unmasked_q.pop_front());
            end else begin
               void'(unmasked_q.pop_front());
            end
         end
         if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_stall) begin
            if (pat_age == 0) begin
               stall_pat = 16'($urandom) | 16'h0001;
               pat_age = $urandom_range(16, 64);
            end else begin
               pat_age--;
            end
            rsp_ch.ready <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WatchdogLimit) begin
            $display("websocket_frame_receiver_top: mismatch");
            $finish;
         end
      end
   end

   initial begin
      req_ch.valid   <= 1'b0;
      req_ch.rx_byte <= '0;
      prs_phase  = PH_HEADER;
      cur_header = '0;
      cur_masked = 1'b0;
      frame_len  = '0;
      frame_cnt  = '0;
      foreach (mask_key_r[i]) mask_key_r[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_literal_127();
      test_extended_length();
      test_backpressure();
      test_random_frames();

      req_ch.valid <= 1'b0;
      rsp_stall <= 1'b0;
      while (unmasked_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && unmasked_q.size() == 0)
         $display("websocket_frame_receiver_top: match");
      else
         $display("websocket_frame_receiver_top: mismatch");
      $finish;
   end

endmodule
